// File: design/ass_pkg.sv
// Package: shared types and codes for the A* search block.
package ass_pkg;

   localparam logic [1:0] CMD_SET_HEUR = 2'd0;
   localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
   localparam logic [1:0] CMD_RUN      = 2'd2;

   localparam int MAX_NODES = 32;
   localparam int GW = 21;
   localparam int FW = 22;
   localparam logic [GW-1:0] G_MAX = {GW{1'b1}};
   localparam logic [FW-1:0] F_MAX = {FW{1'b1}};
   localparam int MAX_OUT = 32;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request fields
      logic clear_step; // clear one node's search state
      logic seed;       // put start in open list
      logic pop;        // take head of open list
      logic edge_rd;    // issue edge memory read
      logic relax;      // evaluate edge read data
      logic ins_step;   // one step of ordered insert
      logic explore;    // mark current node explored
      logic walk_rd;    // read parent of walk pointer
      logic walk_adv;   // advance walk pointer
      logic heur_wr;
      logic edge_wr;
   } ass_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic range_ok;     // start and goal in range
      logic clear_done;
      logic open_empty;
      logic edges_done;   // edge index reached degree
      logic need_insert;  // relax produced an insert
      logic ins_done;
      logic goal_hit;
      logic walk_last;
   } ass_sts_type;

endpackage

// File: design/ass_ram.sv
// Generic single-port-write RAM with registered read.
module ass_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: design/ass_ctrl.sv
// Controller: sequences load, clear, search, and path emission.
module ass_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_cmd,
   input  ass_pkg::ass_sts_type sts,
   output ass_pkg::ass_ctl_type ctl,
   output logic                 busy,
   output logic                 emit,
   output logic                 emit_found
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_POP   = 4'd2;
   localparam logic [3:0] S_EREAD = 4'd3;
   localparam logic [3:0] S_RELAX = 4'd5;
   localparam logic [3:0] S_INS   = 4'd6;
   localparam logic [3:0] S_EXPL  = 4'd7;
   localparam logic [3:0] S_WRD   = 4'd8;
   localparam logic [3:0] S_WOUT  = 4'd9;
   localparam logic [3:0] S_NF    = 4'd10;
   localparam logic [3:0] S_HOLD  = 4'd11;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      emit = 1'b0;
      emit_found = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               ctl.heur_wr = (req_cmd == ass_pkg::CMD_SET_HEUR);
               ctl.edge_wr = (req_cmd == ass_pkg::CMD_ADD_EDGE);
               if (req_cmd == ass_pkg::CMD_RUN) state_in = S_CLEAR;
               else state_in = S_HOLD;
            end
         end
         // a hold state so edge count updates are visible to the next request
         S_HOLD: state_in = S_IDLE;
         S_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (sts.clear_done) begin
               if (sts.range_ok) begin
                  ctl.seed = 1'b1;
                  state_in = S_POP;
               end else state_in = S_NF;
            end
         end
         S_POP: begin
            if (sts.open_empty) state_in = S_NF;
            else begin
               ctl.pop = 1'b1;
               state_in = S_EREAD;
            end
         end
         S_EREAD: begin
            if (sts.edges_done) state_in = S_EXPL;
            else begin
               ctl.edge_rd = 1'b1;
               state_in = S_RELAX;
            end
         end
         S_RELAX: begin
            ctl.relax = 1'b1;
            state_in = sts.need_insert ? S_INS : S_EREAD;
         end
         S_INS: begin
            ctl.ins_step = 1'b1;
            if (sts.ins_done) state_in = S_EREAD;
         end
         S_EXPL: begin
            ctl.explore = 1'b1;
            state_in = sts.goal_hit ? S_WRD : S_POP;
         end
         S_WRD: begin
            ctl.walk_rd = 1'b1;
            state_in = S_WOUT;
         end
         S_WOUT: begin
            emit = 1'b1;
            emit_found = 1'b1;
            ctl.walk_adv = 1'b1;
            state_in = sts.walk_last ? S_IDLE : S_WRD;
         end
         S_NF: begin
            emit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
endmodule

// File: design/ass_dpath.sv
// Datapath: graph tables, search scores, ordered open list, path walk.
module ass_dpath #(
   parameter int MAX_DEGREE = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ass_pkg::ass_ctl_type ctl,
   input  logic [4:0]           req_node_index,
   input  logic [4:0]           req_other_node,
   input  logic [15:0]          req_amount,
   output ass_pkg::ass_sts_type sts,
   output logic [4:0]           walk_node,
   output logic [ass_pkg::GW-1:0] goal_g,
   output logic                 walk_last_o
);
   localparam int MAX_NODES = ass_pkg::MAX_NODES;
   localparam int NW = (MAX_NODES > 32) ? 6 : 5;
   localparam int IW = $clog2(MAX_NODES);
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int KW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int EW = IW + KW;
   localparam int LW = $clog2(MAX_NODES + 1);
   localparam int PW = IW + 1;
   localparam int GW = ass_pkg::GW;
   localparam int FW = ass_pkg::FW;
   localparam int OCW = $clog2(ass_pkg::MAX_OUT + 1);

   // graph tables
   logic [15:0]   heur_ff  [MAX_NODES];
   logic [DW-1:0] ecnt_ff  [MAX_NODES];
   // search state
   logic [GW-1:0] g_ff     [MAX_NODES];
   logic [FW-1:0] f_ff     [MAX_NODES];
   logic [PW-1:0] par_ff   [MAX_NODES];
   logic          expl_ff  [MAX_NODES];
   logic          inlist_ff[MAX_NODES];
   logic [IW-1:0] open_ff  [MAX_NODES];
   logic [LW-1:0] olen_ff;

   logic [NW-1:0] a_ff, b_ff;
   logic [IW-1:0] clr_ff;
   logic [IW-1:0] cur_ff;
   logic [DW-1:0] k_ff, deg_ff;
   logic [IW-1:0] child_ff;
   logic [LW-1:0] ins_pos_ff;  // scan index for insert
   logic          found_ff;
   logic [IW-1:0] walk_ff;
   logic [OCW-1:0] cnt_ff;
   logic [PW-1:0] nxt_ff;

   // edge memories
   logic [EW-1:0] ewa, era;
   logic [4:0]    et_rd;
   logic [15:0]   ec_rd;
   logic          e_we;

   logic a_ok, b_ok;
   assign a_ok = ({1'b0, req_node_index} < 6'(MAX_NODES));
   assign b_ok = ({1'b0, req_other_node} < 6'(MAX_NODES));

   logic [IW-1:0] ra, rb;
   assign ra = req_node_index[IW-1:0];
   assign rb = req_other_node[IW-1:0];

   assign e_we = ctl.edge_wr && a_ok && b_ok && (ecnt_ff[ra] < DW'(MAX_DEGREE));
   assign ewa  = {ra, ecnt_ff[ra][KW-1:0]};
   assign era  = {cur_ff, k_ff[KW-1:0]};

   ass_ram #(.WIDTH(5), .DEPTH(MAX_NODES << KW)) u_tgt (
      .clock(clock), .wr_en(e_we), .wr_addr(ewa), .wr_data(req_other_node),
      .rd_addr(era), .rd_data(et_rd));
   ass_ram #(.WIDTH(16), .DEPTH(MAX_NODES << KW)) u_cost (
      .clock(clock), .wr_en(e_we), .wr_addr(ewa), .wr_data(req_amount),
      .rd_addr(era), .rd_data(ec_rd));

   // relax arithmetic on the edge just read
   logic [IW-1:0] c_idx;
   logic          c_ok;
   logic [GW:0]   g_sum;
   logic [GW-1:0] g_new;
   logic [FW:0]   f_sum;
   logic [FW-1:0] f_new;
   logic          better, ins_new;
   assign c_idx = et_rd[IW-1:0];
   assign c_ok  = ({1'b0, et_rd} < 6'(MAX_NODES)) && (c_idx != cur_ff) && !expl_ff[c_idx];
   assign g_sum = {1'b0, g_ff[cur_ff]} + (GW+1)'(ec_rd);
   assign g_new = g_sum[GW] ? ass_pkg::G_MAX : g_sum[GW-1:0];
   assign f_sum = (FW+1)'(g_new) + (FW+1)'(heur_ff[c_idx]);
   assign f_new = f_sum[FW] ? ass_pkg::F_MAX : f_sum[FW-1:0];
   assign better  = c_ok && (f_new < f_ff[c_idx]);
   assign ins_new = c_ok && !better && !inlist_ff[c_idx];

   // entries after the child's old slot move one place toward the head
   logic [MAX_NODES-1:0] rm_hit;
   logic                 rm_seen;
   always_comb begin
      rm_seen = 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (LW'(i) < olen_ff && open_ff[i] == c_idx) rm_seen = 1'b1;
         rm_hit[i] = rm_seen;
      end
   end

   // insert scan: position ins_pos_ff holds the candidate a+1
   logic [FW-1:0] fc;
   logic          adv;
   logic [IW-1:0] ip;
   assign fc = f_ff[child_ff];
   assign ip = ins_pos_ff[IW-1:0];
   assign adv = (ins_pos_ff < olen_ff) && (fc >= f_ff[open_ff[ip]]);

   logic [LW-1:0] ins_at;
   always_comb begin
      if (olen_ff == '0) ins_at = '0;
      else if (!adv && ins_pos_ff == LW'(1) && fc <= f_ff[open_ff[0]]) ins_at = '0;
      else ins_at = adv ? ins_pos_ff : ins_pos_ff;
   end
   // when not advancing, insert goes at ins_pos_ff (= a+1) unless head case

   assign sts.range_ok    = ({1'b0, a_ff} < (NW+1)'(MAX_NODES)) &&
                            ({1'b0, b_ff} < (NW+1)'(MAX_NODES));
   assign sts.clear_done  = (clr_ff == IW'(MAX_NODES - 1));
   assign sts.open_empty  = (olen_ff == '0);
   assign sts.edges_done  = (k_ff >= deg_ff);
   assign sts.need_insert = better || ins_new;
   assign sts.ins_done    = !adv;
   assign sts.goal_hit    = found_ff;
   assign sts.walk_last   = walk_last_o;

   assign walk_node   = 5'(walk_ff);
   assign goal_g      = g_ff[b_ff[IW-1:0]];
   assign walk_last_o = (nxt_ff >= PW'(MAX_NODES)) || (cnt_ff == OCW'(ass_pkg::MAX_OUT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            heur_ff[i]   <= '0;
            ecnt_ff[i]   <= '0;
            g_ff[i]      <= '0;
            f_ff[i]      <= '0;
            par_ff[i]    <= PW'(MAX_NODES);
            expl_ff[i]   <= 1'b0;
            inlist_ff[i] <= 1'b0;
         end
         olen_ff <= '0;
         clr_ff  <= '0;
         found_ff <= 1'b0;
         k_ff <= '0;
         deg_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (ctl.load) begin
            a_ff <= req_node_index;
            b_ff <= req_other_node;
            clr_ff <= '0;
            found_ff <= 1'b0;
            olen_ff <= '0;
         end
         if (ctl.heur_wr && a_ok) heur_ff[ra] <= req_amount;
         if (e_we) ecnt_ff[ra] <= ecnt_ff[ra] + DW'(1);
         if (ctl.clear_step) begin
            g_ff[clr_ff] <= '0;
            f_ff[clr_ff] <= '0;
            par_ff[clr_ff] <= PW'(MAX_NODES);
            expl_ff[clr_ff] <= 1'b0;
            inlist_ff[clr_ff] <= 1'b0;
            clr_ff <= clr_ff + IW'(1);
         end
         // start is popped straight away, so its list flag stays clear
         if (ctl.seed) begin
            open_ff[0] <= a_ff[IW-1:0];
            olen_ff <= LW'(1);
         end
         if (ctl.pop) begin
            cur_ff <= open_ff[0];
            deg_ff <= (ecnt_ff[open_ff[0]] > DW'(MAX_DEGREE)) ? DW'(MAX_DEGREE)
                                                              : ecnt_ff[open_ff[0]];
            k_ff <= '0;
            if (open_ff[0] == b_ff[IW-1:0]) found_ff <= 1'b1;
            inlist_ff[open_ff[0]] <= 1'b0;
            for (int i = 0; i + 1 < MAX_NODES; i++) open_ff[i] <= open_ff[i+1];
            olen_ff <= olen_ff - LW'(1);
         end
         if (ctl.edge_rd) k_ff <= k_ff + DW'(1);
         if (ctl.relax && (better || ins_new)) begin
            par_ff[c_idx] <= PW'(cur_ff);
            g_ff[c_idx] <= g_new;
            f_ff[c_idx] <= f_new;
            child_ff <= c_idx;
            ins_pos_ff <= LW'(1);
            if (better && inlist_ff[c_idx]) begin
               // drop the old entry from the list
               for (int i = 0; i + 1 < MAX_NODES; i++)
                  if (rm_hit[i]) open_ff[i] <= open_ff[i+1];
               olen_ff <= olen_ff - LW'(1);
            end
            inlist_ff[c_idx] <= 1'b1;
         end
         if (ctl.ins_step) begin
            if (adv) ins_pos_ff <= ins_pos_ff + LW'(1);
            else if (olen_ff < LW'(MAX_NODES)) begin
               for (int i = 1; i < MAX_NODES; i++)
                  if (LW'(i) > ins_at && LW'(i) <= olen_ff) open_ff[i] <= open_ff[i-1];
               open_ff[ins_at[IW-1:0]] <= child_ff;
               olen_ff <= olen_ff + LW'(1);
            end
         end
         if (ctl.explore) begin
            expl_ff[cur_ff] <= 1'b1;
            walk_ff <= b_ff[IW-1:0];
            cnt_ff <= '0;
         end
         if (ctl.walk_rd) nxt_ff <= par_ff[walk_ff];
         if (ctl.walk_adv) begin
            walk_ff <= nxt_ff[IW-1:0];
            cnt_ff <= cnt_ff + OCW'(1);
         end
      end
   end
endmodule

// File: design/a_star_shortest_path.sv
// Top level: A* shortest-path search engine over a loaded graph.
// Usage: drive req_* and pulse start while busy is low. cmd 0 sets a node's
// heuristic, cmd 1 appends an edge (ignored past the degree limit), cmd 2
// runs a search from req_node_index to req_other_node.
// A load request keeps busy high for one cycle, in the hold state.
// A run first clears per-node search state, one node a cycle, then pops
// open-list heads; each edge is read, then scored, then if needed put in
// the open list by an ordered insert scan. Results then leave in turn,
// goal first, start last, each on rsp_* for one cycle with rsp_valid
// high; rsp_last marks the final one. A not-found run gives a single
// result with rsp_found low.
// The receiver cannot stall; results are presented once only.
// Reset (synchronous) clears heuristics, edge counts and search state;
// edge memories are left undefined and read only below the edge count.
module a_star_shortest_path #(
   parameter int MAX_DEGREE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_node_index,
   input  logic [4:0]  req_other_node,
   input  logic [15:0] req_amount,
   output logic        rsp_valid,
   output logic [4:0]  rsp_path_node,
   output logic        rsp_found,
   output logic [20:0] rsp_goal_cost,
   output logic        rsp_last
);
   ass_pkg::ass_ctl_type ctl;
   ass_pkg::ass_sts_type sts;
   logic emit, emit_found;
   logic [4:0] walk_node;
   logic [20:0] goal_g;
   logic walk_last;

   ass_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_cmd(req_cmd),
      .sts(sts), .ctl(ctl), .busy(busy), .emit(emit), .emit_found(emit_found));

   ass_dpath #(.MAX_DEGREE(MAX_DEGREE)) u_dpath (
      .clock(clock), .reset(reset), .ctl(ctl),
      .req_node_index(req_node_index), .req_other_node(req_other_node),
      .req_amount(req_amount), .sts(sts), .walk_node(walk_node),
      .goal_g(goal_g), .walk_last_o(walk_last));

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= emit;
      rsp_found     <= emit_found;
      rsp_path_node <= emit_found ? walk_node : 5'd0;
      rsp_goal_cost <= emit_found ? goal_g : 21'd0;
      rsp_last      <= emit_found ? walk_last : 1'b1;
   end
endmodule

// File: design/ass_checker.sv
// Checker on the top-level ports, bound to the top level.
module ass_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_found,
   input logic rsp_last,
   input logic [20:0] rsp_goal_cost
);
   a_nf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_goal_cost == 21'd0)
      else $error("not-found result malformed");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request not taken");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("idle mid path");
   a_cost_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid, 2) && !$past(rsp_last, 2) && rsp_found
      |-> rsp_goal_cost == $past(rsp_goal_cost, 2))
      else $error("goal cost changed within path");
endmodule

bind a_star_shortest_path ass_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_found(rsp_found), .rsp_last(rsp_last),
   .rsp_goal_cost(rsp_goal_cost));
